>>> rtl/prs_pkg.sv
package prs_pkg;

  // Fixed-point formats. Coordinates carry their own fraction bits, but they all
  // share one format, so only the trig and scale fractions shape the datapath.
  localparam int unsigned CoordW         = 16;
  localparam int unsigned ScaleW         = 16;
  localparam int unsigned AngleW         = 9;
  localparam int unsigned TRIG_FRAC_BITS = 14;
  localparam int unsigned SCALE_FRAC_BITS = 8;
  localparam int unsigned TrigW          = TRIG_FRAC_BITS + 2;
  localparam int unsigned MagW           = TRIG_FRAC_BITS + 1;
  localparam int unsigned ProdW          = TrigW + CoordW;
  localparam int unsigned DiffW          = ProdW + 1;
  localparam int unsigned ScaledW        = DiffW + ScaleW;
  localparam int unsigned SumW           = ScaledW + 1;
  localparam int unsigned FinalShift     = TRIG_FRAC_BITS + SCALE_FRAC_BITS;
  localparam int unsigned RoundW         = SumW - FinalShift;

  // The sine table is stored in Q1.14 and moved to the trig format on lookup.
  // A finer format shifts it up; a coarser one rounds its magnitude half up.
  localparam int unsigned TableFrac      = 14;
  localparam int unsigned TableW         = TableFrac + 1;
  localparam int unsigned TrigUpShift    =
    (TRIG_FRAC_BITS >= TableFrac) ? TRIG_FRAC_BITS - TableFrac : 0;
  localparam int unsigned TrigDownShift  =
    (TRIG_FRAC_BITS < TableFrac) ? TableFrac - TRIG_FRAC_BITS : 0;
  localparam int unsigned TrigWideW      = TableW + TrigUpShift + 1;
  localparam logic [TrigWideW-1:0] TrigHalf = TrigWideW'((1 << TrigDownShift) >> 1);

  // Configuration register indexes.
  typedef enum logic [2:0] {
    RegScaleX   = 3'd0,
    RegScaleY   = 3'd1,
    RegPivotX   = 3'd2,
    RegPivotY   = 3'd3,
    RegAngleDeg = 3'd4
  } cfg_reg_e;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic signed [ScaleW-1:0] scale_x;
    logic signed [ScaleW-1:0] scale_y;
    logic signed [CoordW-1:0] pivot_x;
    logic signed [CoordW-1:0] pivot_y;
    logic        [AngleW-1:0] angle_deg;
  } cfg_t;

  // Quarter-wave sine table, Q1.14, one entry per whole degree.
  localparam logic [TableW-1:0] QuarterSine [0:90] = '{
    15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
    15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
    15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
    15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
    15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
    15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
    15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
    15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189,
    15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849, 15'd14968,
    15'd15082, 15'd15191, 15'd15296, 15'd15396, 15'd15491, 15'd15582,
    15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964, 15'd16026,
    15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
    15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  // Sine of an angle in 0..359 degrees, folded onto the quarter wave.
  function automatic logic signed [TrigW-1:0] sine_deg(input logic [AngleW-1:0] a);
    logic [AngleW-1:0]    idx;
    logic                 neg;
    logic [MagW-1:0]      mag;
    logic [TrigWideW-1:0] wide;
    if (a <= AngleW'(90)) begin
      idx = a;
      neg = 1'b0;
    end else if (a <= AngleW'(180)) begin
      idx = AngleW'(180) - a;
      neg = 1'b0;
    end else if (a <= AngleW'(270)) begin
      idx = a - AngleW'(180);
      neg = 1'b1;
    end else begin
      idx = AngleW'(360) - a;
      neg = 1'b1;
    end
    wide = (TrigWideW'(QuarterSine[idx[6:0]]) << TrigUpShift) + TrigHalf;
    mag  = MagW'(wide >> TrigDownShift);
    sine_deg = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

>>> rtl/point_rotate_scale_about_pivot_unit.sv
// Rotate about the origin, then scale about a pivot, one point per request.
// A request passes through stages A to E; stage E is the output register.
// Throughput: one point per cycle; each of the five stages holds its item on a
// stall and takes a new one as soon as it empties.
// Reset clears all stage valid bits and loads unit scale, zero pivot and zero angle.
module point_rotate_scale_about_pivot_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [2:0]                           cfg_index_i,
  input  logic [prs_pkg::CoordW-1:0]           cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [prs_pkg::CoordW-1:0]    point_x_i,
  input  logic signed [prs_pkg::CoordW-1:0]    point_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [prs_pkg::CoordW-1:0]    out_x_o,
  output logic signed [prs_pkg::CoordW-1:0]    out_y_o,
  output logic                                 overflow_o
);

  prs_pkg::cfg_t                      cfg_q;
  logic                               mid_valid, mid_ready;
  logic signed [prs_pkg::DiffW-1:0]   mid_dx, mid_dy;

  assign cfg_ready_o = 1'b1;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale_x   <= prs_pkg::ScaleW'(256);
      cfg_q.scale_y   <= prs_pkg::ScaleW'(256);
      cfg_q.pivot_x   <= '0;
      cfg_q.pivot_y   <= '0;
      cfg_q.angle_deg <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        prs_pkg::RegScaleX:   cfg_q.scale_x   <= cfg_data_i;
        prs_pkg::RegScaleY:   cfg_q.scale_y   <= cfg_data_i;
        prs_pkg::RegPivotX:   cfg_q.pivot_x   <= cfg_data_i;
        prs_pkg::RegPivotY:   cfg_q.pivot_y   <= cfg_data_i;
        prs_pkg::RegAngleDeg: cfg_q.angle_deg <= cfg_data_i[prs_pkg::AngleW-1:0];
        default: ;
      endcase
    end
  end

  // Rotation and pivot offset.
  prs_rotate u_rotate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .dx_o        (mid_dx),
    .dy_o        (mid_dy)
  );

  // Scaling, rounding and saturation.
  prs_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .dx_i        (mid_dx),
    .dy_i        (mid_dy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .overflow_o  (overflow_o)
  );

endmodule

>>> rtl/prs_rotate.sv
module prs_rotate (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  prs_pkg::cfg_t                        cfg_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [prs_pkg::CoordW-1:0]    point_x_i,
  input  logic signed [prs_pkg::CoordW-1:0]    point_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [prs_pkg::DiffW-1:0]     dx_o,
  output logic signed [prs_pkg::DiffW-1:0]     dy_o
);

  logic [prs_pkg::AngleW-1:0]         ang_red;
  logic [prs_pkg::AngleW:0]           cos_sum;
  logic [prs_pkg::AngleW-1:0]         cos_ang;
  logic                               en_a, en_b, en_c;
  logic                               va_q, vb_q, vc_q;
  logic signed [prs_pkg::CoordW-1:0]  x_q, y_q;
  logic signed [prs_pkg::TrigW-1:0]   sin_q, cos_q;
  logic signed [prs_pkg::ProdW-1:0]   cx_q, sy_q, sx_q, cy_q;
  logic signed [prs_pkg::DiffW-1:0]   dx_q, dy_q;
  logic signed [prs_pkg::DiffW-1:0]   pivx_term, pivy_term;

  // Stage enables: a stage loads when it is empty or its content moves on.
  assign en_c       = !vc_q || out_ready_i;
  assign en_b       = !vb_q || en_c;
  assign en_a       = !va_q || en_b;
  assign in_ready_o = en_a;

  // Angle reduction and the cosine angle, a quarter turn ahead.
  always_comb begin
    ang_red = (cfg_i.angle_deg >= prs_pkg::AngleW'(360))
            ? cfg_i.angle_deg - prs_pkg::AngleW'(360) : cfg_i.angle_deg;
    cos_sum = {1'b0, ang_red} + (prs_pkg::AngleW + 1)'(90);
    cos_ang = (cos_sum >= (prs_pkg::AngleW + 1)'(360))
            ? prs_pkg::AngleW'(cos_sum - (prs_pkg::AngleW + 1)'(360))
            : prs_pkg::AngleW'(cos_sum);
  end

  // Pivot moved into the product format of the rotation stage.
  assign pivx_term = $signed({{(prs_pkg::DiffW - prs_pkg::CoordW - prs_pkg::TRIG_FRAC_BITS)
                               {cfg_i.pivot_x[prs_pkg::CoordW-1]}},
                              cfg_i.pivot_x, {prs_pkg::TRIG_FRAC_BITS{1'b0}}});
  assign pivy_term = $signed({{(prs_pkg::DiffW - prs_pkg::CoordW - prs_pkg::TRIG_FRAC_BITS)
                               {cfg_i.pivot_y[prs_pkg::CoordW-1]}},
                              cfg_i.pivot_y, {prs_pkg::TRIG_FRAC_BITS{1'b0}}});

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (en_a) va_q <= in_valid_i;
      if (en_b) vb_q <= va_q;
      if (en_c) vc_q <= vb_q;
    end
  end

  // Stage A: point and the sine and cosine looked up for it.
  always_ff @(posedge clk_i) begin
    if (en_a && in_valid_i) begin
      x_q   <= point_x_i;
      y_q   <= point_y_i;
      sin_q <= prs_pkg::sine_deg(ang_red);
      cos_q <= prs_pkg::sine_deg(cos_ang);
    end
  end

  // Stage B: the four rotation products.
  always_ff @(posedge clk_i) begin
    if (en_b && va_q) begin
      cx_q <= cos_q * x_q;
      sy_q <= sin_q * y_q;
      sx_q <= sin_q * x_q;
      cy_q <= cos_q * y_q;
    end
  end

  // Stage C: rotated point relative to the pivot.
  always_ff @(posedge clk_i) begin
    if (en_c && vb_q) begin
      dx_q <= prs_pkg::DiffW'(cx_q) - prs_pkg::DiffW'(sy_q) - pivx_term;
      dy_q <= prs_pkg::DiffW'(sx_q) + prs_pkg::DiffW'(cy_q) - pivy_term;
    end
  end

  assign out_valid_o = vc_q;
  assign dx_o        = dx_q;
  assign dy_o        = dy_q;

endmodule

>>> rtl/prs_scale.sv
module prs_scale (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  prs_pkg::cfg_t                        cfg_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [prs_pkg::DiffW-1:0]     dx_i,
  input  logic signed [prs_pkg::DiffW-1:0]     dy_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [prs_pkg::CoordW-1:0]    out_x_o,
  output logic signed [prs_pkg::CoordW-1:0]    out_y_o,
  output logic                                 overflow_o
);

  localparam int unsigned PadW = prs_pkg::SumW - prs_pkg::CoordW - prs_pkg::FinalShift;

  logic                                en_d, en_e;
  logic                                vd_q, ve_q;
  logic signed [prs_pkg::ScaledW-1:0]  mx_q, my_q;
  logic signed [prs_pkg::SumW-1:0]     sum_x, sum_y;
  logic signed [prs_pkg::RoundW-1:0]   rnd_x, rnd_y;
  logic signed [prs_pkg::CoordW-1:0]   sat_x, sat_y;
  logic                                ovf_x, ovf_y;
  logic signed [prs_pkg::CoordW-1:0]   out_x_q, out_y_q;
  logic                                ovf_q;

  localparam logic signed [prs_pkg::RoundW-1:0] MaxR =
    prs_pkg::RoundW'((1 << (prs_pkg::CoordW - 1)) - 1);
  localparam logic signed [prs_pkg::RoundW-1:0] MinR =
    -prs_pkg::RoundW'(1 << (prs_pkg::CoordW - 1));
  localparam logic signed [prs_pkg::SumW-1:0] Half =
    prs_pkg::SumW'(1) << (prs_pkg::FinalShift - 1);

  assign en_e       = !ve_q || out_ready_i;
  assign en_d       = !vd_q || en_e;
  assign in_ready_o = en_d;

  // Add the pivot back, round half up and keep the integer part.
  always_comb begin
    sum_x = prs_pkg::SumW'(mx_q) + Half
          + $signed({{PadW{cfg_i.pivot_x[prs_pkg::CoordW-1]}}, cfg_i.pivot_x,
                     {prs_pkg::FinalShift{1'b0}}});
    sum_y = prs_pkg::SumW'(my_q) + Half
          + $signed({{PadW{cfg_i.pivot_y[prs_pkg::CoordW-1]}}, cfg_i.pivot_y,
                     {prs_pkg::FinalShift{1'b0}}});
    rnd_x = sum_x[prs_pkg::SumW-1:prs_pkg::FinalShift];
    rnd_y = sum_y[prs_pkg::SumW-1:prs_pkg::FinalShift];
  end

  // Saturate each coordinate to the output range.
  always_comb begin
    ovf_x = 1'b1;
    ovf_y = 1'b1;
    if (rnd_x > MaxR) begin
      sat_x = MaxR[prs_pkg::CoordW-1:0];
    end else if (rnd_x < MinR) begin
      sat_x = MinR[prs_pkg::CoordW-1:0];
    end else begin
      sat_x = rnd_x[prs_pkg::CoordW-1:0];
      ovf_x = 1'b0;
    end
    if (rnd_y > MaxR) begin
      sat_y = MaxR[prs_pkg::CoordW-1:0];
    end else if (rnd_y < MinR) begin
      sat_y = MinR[prs_pkg::CoordW-1:0];
    end else begin
      sat_y = rnd_y[prs_pkg::CoordW-1:0];
      ovf_y = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      if (en_d) vd_q <= in_valid_i;
      if (en_e) ve_q <= vd_q;
    end
  end

  // Stage D: scale products.
  always_ff @(posedge clk_i) begin
    if (en_d && in_valid_i) begin
      mx_q <= prs_pkg::ScaledW'(cfg_i.scale_x) * prs_pkg::ScaledW'(dx_i);
      my_q <= prs_pkg::ScaledW'(cfg_i.scale_y) * prs_pkg::ScaledW'(dy_i);
    end
  end

  // Stage E: output register.
  always_ff @(posedge clk_i) begin
    if (en_e && vd_q) begin
      out_x_q <= sat_x;
      out_y_q <= sat_y;
      ovf_q   <= ovf_x || ovf_y;
    end
  end

  assign out_valid_o = ve_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign overflow_o  = ovf_q;

endmodule

>>> dv/tb_point_rotate_scale_about_pivot_unit.sv
`timescale 1ns / 1ps

module tb_point_rotate_scale_about_pivot_unit;

  localparam int unsigned PipeLatency = 5;
  localparam int unsigned ReportLimit = 40;
  localparam logic [2:0]  RegIdxMax   = 3'd7;
  localparam int unsigned FullFrac    = prs_pkg::TRIG_FRAC_BITS + prs_pkg::SCALE_FRAC_BITS;
  localparam longint      CoordMax    = 32767;
  localparam longint      CoordMin    = -32768;

  // Receiver stall behaviors, switched at random.
  typedef enum int unsigned {
    ReadyAlways,
    ReadyCoinFlip,
    ReadyMostly,
    ReadyRarely
  } stall_mode_e;

  // One transformed point as the block should report it.
  typedef struct packed {
    logic signed [prs_pkg::CoordW-1:0] x;
    logic signed [prs_pkg::CoordW-1:0] y;
    logic                              ovf;
  } point_result_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  logic [2:0]                        cfg_index_i;
  logic [prs_pkg::CoordW-1:0]        cfg_data_i;
  logic                              in_valid_i;
  logic                              in_ready_o;
  logic signed [prs_pkg::CoordW-1:0] point_x_i;
  logic signed [prs_pkg::CoordW-1:0] point_y_i;
  logic                              out_valid_o;
  logic                              out_ready_i;
  logic signed [prs_pkg::CoordW-1:0] out_x_o;
  logic signed [prs_pkg::CoordW-1:0] out_y_o;
  logic                              overflow_o;

  // Shadow copy of the configuration registers.
  prs_pkg::cfg_t point_cfg = '{scale_x: 16'sd256, scale_y: 16'sd256, pivot_x: '0,
                               pivot_y: '0, angle_deg: '0};

  point_result_t expected_points[$];
  int unsigned   burst_left;
  int unsigned   points_sent;
  int unsigned   results_checked;
  int unsigned   saturated_results;
  int unsigned   cfg_writes;
  int unsigned   error_count;

  point_rotate_scale_about_pivot_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .overflow_o  (overflow_o)
  );

  // Sine of a whole angle in 0..359 degrees, folded onto the quarter-wave table
  // and moved from Q1.14 to the trig format.
  function automatic longint trig_lookup(input int unsigned a);
    int unsigned idx;
    bit          neg;
    longint      mag;
    if (a <= 90) begin
      idx = a;
      neg = 1'b0;
    end else if (a <= 180) begin
      idx = 180 - a;
      neg = 1'b0;
    end else if (a <= 270) begin
      idx = a - 180;
      neg = 1'b1;
    end else begin
      idx = 360 - a;
      neg = 1'b1;
    end
    mag = longint'(prs_pkg::QuarterSine[idx]);
    if (prs_pkg::TRIG_FRAC_BITS >= prs_pkg::TableFrac)
      mag = mag <<< (prs_pkg::TRIG_FRAC_BITS - prs_pkg::TableFrac);
    else
      mag = (mag + (longint'(1) <<< (prs_pkg::TableFrac - prs_pkg::TRIG_FRAC_BITS - 1)))
            >>> (prs_pkg::TableFrac - prs_pkg::TRIG_FRAC_BITS);
    return neg ? -mag : mag;
  endfunction

  // Round to nearest with ties upward, then clamp; the top bit flags a clamp.
  function automatic logic [prs_pkg::CoordW:0] round_saturate(input longint v);
    longint r;
    r = (v + (longint'(1) <<< (FullFrac - 1))) >>> FullFrac;
    if (r > CoordMax) return {1'b1, CoordMax[prs_pkg::CoordW-1:0]};
    if (r < CoordMin) return {1'b1, CoordMin[prs_pkg::CoordW-1:0]};
    return {1'b0, r[prs_pkg::CoordW-1:0]};
  endfunction

  // Rotate about the origin, then scale about the pivot, all in exact integers.
  function automatic point_result_t rotate_scale_point(
      input prs_pkg::cfg_t cfg,
      input logic signed [prs_pkg::CoordW-1:0] px,
      input logic signed [prs_pkg::CoordW-1:0] py);
    int unsigned              ang;
    int unsigned              cos_ang;
    longint                   sn, cs, x, y, pvx, pvy, scx, scy, one_trig, one_full;
    logic [prs_pkg::CoordW:0] rx, ry;
    point_result_t            res;
    ang = cfg.angle_deg;
    if (ang >= 360) ang -= 360;
    cos_ang = ang + 90;
    if (cos_ang >= 360) cos_ang -= 360;
    sn = trig_lookup(ang);
    cs = trig_lookup(cos_ang);
    x = longint'(px);
    y = longint'(py);
    pvx = longint'($signed(cfg.pivot_x));
    pvy = longint'($signed(cfg.pivot_y));
    scx = longint'($signed(cfg.scale_x));
    scy = longint'($signed(cfg.scale_y));
    one_trig = longint'(1) <<< prs_pkg::TRIG_FRAC_BITS;
    one_full = longint'(1) <<< FullFrac;
    rx = round_saturate(scx * (cs * x - sn * y - pvx * one_trig) + pvx * one_full);
    ry = round_saturate(scy * (sn * x + cs * y - pvy * one_trig) + pvy * one_full);
    res.x = rx[prs_pkg::CoordW-1:0];
    res.y = ry[prs_pkg::CoordW-1:0];
    res.ovf = rx[prs_pkg::CoordW] | ry[prs_pkg::CoordW];
    return res;
  endfunction

  function automatic logic [prs_pkg::CoordW-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  // Mostly moderate coordinates so that many results stay unsaturated.
  function automatic logic [prs_pkg::CoordW-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return pick_extreme();
      1, 2, 3, 4: return prs_pkg::CoordW'($urandom());
      default: return prs_pkg::CoordW'($urandom_range(0, 4095) - 2048);
    endcase
  endfunction

  // Scales mostly within plus or minus four.
  function automatic logic [prs_pkg::CoordW-1:0] pick_scale();
    case ($urandom_range(0, 5))
      0: return pick_extreme();
      1: return prs_pkg::CoordW'($urandom());
      default: return prs_pkg::CoordW'($urandom_range(0, 2048) - 1024);
    endcase
  endfunction

  // Angle write data; the bits above the angle field are random and unused.
  function automatic logic [prs_pkg::CoordW-1:0] pick_angle_data();
    logic [prs_pkg::AngleW-1:0] a;
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 6))
        0: a = prs_pkg::AngleW'(0);
        1: a = prs_pkg::AngleW'(90);
        2: a = prs_pkg::AngleW'(180);
        3: a = prs_pkg::AngleW'(270);
        4: a = prs_pkg::AngleW'(359);
        5: a = prs_pkg::AngleW'(360);
        default: a = prs_pkg::AngleW'(511);
      endcase
    end else begin
      a = prs_pkg::AngleW'($urandom_range(0, 511));
    end
    return {(prs_pkg::CoordW - prs_pkg::AngleW)'($urandom()), a};
  endfunction

  // Register write, issued only once every outstanding point has come back.
  task automatic write_reg(input logic [2:0] idx, input logic [prs_pkg::CoordW-1:0] value);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat ($urandom_range(1, 3)) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    case (idx)
      prs_pkg::RegScaleX:   point_cfg.scale_x   = value;
      prs_pkg::RegScaleY:   point_cfg.scale_y   = value;
      prs_pkg::RegPivotX:   point_cfg.pivot_x   = value;
      prs_pkg::RegPivotY:   point_cfg.pivot_y   = value;
      prs_pkg::RegAngleDeg: point_cfg.angle_deg = value[prs_pkg::AngleW-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Send one point request; the sender runs in random bursts with gaps between.
  task automatic send_point(input logic [prs_pkg::CoordW-1:0] x,
                            input logic [prs_pkg::CoordW-1:0] y);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(8, 30)) @(posedge clk_i);
      else repeat ($urandom_range(1, 4)) @(posedge clk_i);
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    point_x_i  <= x;
    point_y_i  <= y;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    expected_points.insert(expected_points.size(), rotate_scale_point(point_cfg, x, y));
    points_sent++;
  endtask

  // Reset configuration is the identity, so extreme points must pass unchanged.
  task automatic test_identity_extremes();
    send_point(16'h0000, 16'h0000);
    send_point(16'h7FFF, 16'h7FFF);
    send_point(16'h8000, 16'h8000);
    send_point(16'h8000, 16'h7FFF);
  endtask

  // Quadrant folding and angles of 360 and above, which wrap back by 360.
  task automatic test_angle_folding();
    write_reg(prs_pkg::RegAngleDeg, 16'd90);
    send_point(16'h7FFF, 16'h8000);
    write_reg(prs_pkg::RegAngleDeg, 16'd180);
    send_point(16'h7FFF, 16'h8000);
    write_reg(prs_pkg::RegAngleDeg, 16'd270);
    send_point(16'd1000, -16'sd500);
    write_reg(prs_pkg::RegAngleDeg, 16'd359);
    send_point(16'd1000, -16'sd500);
    write_reg(prs_pkg::RegAngleDeg, 16'd360);
    send_point(16'd1000, -16'sd500);
    write_reg(prs_pkg::RegAngleDeg, 16'hFFFF);
    send_point(16'd1000, -16'sd500);
  endtask

  // Largest and most negative scales drive both outputs into the clamps.
  task automatic test_saturation();
    write_reg(prs_pkg::RegAngleDeg, 16'd0);
    write_reg(prs_pkg::RegScaleX, 16'h7FFF);
    write_reg(prs_pkg::RegScaleY, 16'h8000);
    send_point(16'h7FFF, 16'h7FFF);
    send_point(16'h8000, 16'h8000);
  endtask

  // Half scale on odd coordinates lands exactly on ties, which round upward.
  task automatic test_rounding_ties();
    write_reg(prs_pkg::RegScaleX, 16'd128);
    write_reg(prs_pkg::RegScaleY, 16'd128);
    send_point(16'd1, -16'sd1);
    send_point(16'd3, -16'sd3);
  endtask

  // Zero scale collapses every point onto the pivot.
  task automatic test_pivot_only();
    write_reg(prs_pkg::RegScaleX, 16'd0);
    write_reg(prs_pkg::RegScaleY, 16'd0);
    write_reg(prs_pkg::RegPivotX, 16'h7FFF);
    write_reg(prs_pkg::RegPivotY, 16'h8000);
    send_point(16'h1234, 16'h8765);
  endtask

  // Writes to indexes past the last register must change nothing.
  task automatic test_unused_index();
    write_reg(prs_pkg::RegScaleX, 16'd256);
    write_reg(prs_pkg::RegScaleY, 16'd256);
    for (logic [3:0] idx = prs_pkg::RegAngleDeg + 1; idx <= RegIdxMax; idx++)
      write_reg(idx[2:0], prs_pkg::CoordW'($urandom()));
    send_point(16'h0123, 16'hFEDC);
    send_point(16'h8000, 16'h0001);
  endtask

  // Random settings, with the two corner settings first, each followed by a
  // stream of random points.
  task automatic test_random_settings(input int unsigned n_phases,
                                      input int unsigned points_per_phase);
    for (int unsigned phase = 0; phase < n_phases; phase++) begin
      case (phase)
        0: begin
          write_reg(prs_pkg::RegScaleX, 16'h7FFF);
          write_reg(prs_pkg::RegScaleY, 16'h7FFF);
          write_reg(prs_pkg::RegPivotX, 16'h7FFF);
          write_reg(prs_pkg::RegPivotY, 16'h7FFF);
          write_reg(prs_pkg::RegAngleDeg, 16'hFFFF);
        end
        1: begin
          write_reg(prs_pkg::RegScaleX, 16'h8000);
          write_reg(prs_pkg::RegScaleY, 16'h8000);
          write_reg(prs_pkg::RegPivotX, 16'h8000);
          write_reg(prs_pkg::RegPivotY, 16'h8000);
          write_reg(prs_pkg::RegAngleDeg, 16'h0000);
        end
        default: begin
          write_reg(prs_pkg::RegScaleX, pick_scale());
          write_reg(prs_pkg::RegScaleY, pick_scale());
          write_reg(prs_pkg::RegPivotX, pick_coord());
          write_reg(prs_pkg::RegPivotY, pick_coord());
          write_reg(prs_pkg::RegAngleDeg, pick_angle_data());
          if ($urandom_range(0, 5) == 0)
            write_reg(3'($urandom_range(prs_pkg::RegAngleDeg + 1, RegIdxMax)),
                      prs_pkg::CoordW'($urandom()));
        end
      endcase
      repeat (points_per_phase) send_point(pick_coord(), pick_coord());
    end
  endtask

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver ready follows a random mix of stall patterns.
  initial begin
    stall_mode_e mode;
    int unsigned span;
    out_ready_i <= 1'b0;
    forever begin
      mode = stall_mode_e'($urandom_range(ReadyAlways, ReadyRarely));
      span = $urandom_range(8, 64);
      repeat (span) begin
        @(posedge clk_i);
        case (mode)
          ReadyAlways:   out_ready_i <= 1'b1;
          ReadyCoinFlip: out_ready_i <= ($urandom_range(0, 1) == 1);
          ReadyMostly:   out_ready_i <= ($urandom_range(0, 7) != 0);
          default:       out_ready_i <= ($urandom_range(0, 15) < 3);
        endcase
      end
    end
  end

  // Compare every accepted result with the oldest outstanding prediction.
  initial begin
    point_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
        if (expected_points.size() == 0) begin
          error_count++;
          if (error_count <= ReportLimit)
            $display("%0t: unexpected result x %0d y %0d overflow %0b", $time,
                     out_x_o, out_y_o, overflow_o);
        end else begin
          want = expected_points.pop_front();
          results_checked++;
          if (overflow_o === 1'b1) saturated_results++;
          if (out_x_o !== want.x) begin
            error_count++;
            if (error_count <= ReportLimit)
              $display("%0t: out_x expected %0d actual %0d", $time, want.x, out_x_o);
          end
          if (out_y_o !== want.y) begin
            error_count++;
            if (error_count <= ReportLimit)
              $display("%0t: out_y expected %0d actual %0d", $time, want.y, out_y_o);
          end
          if (overflow_o !== want.ovf) begin
            error_count++;
            if (error_count <= ReportLimit)
              $display("%0t: overflow expected %0b actual %0b", $time, want.ovf,
                       overflow_o);
          end
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #5ms;
    $display("FAIL point_rotate_scale_about_pivot_unit");
    $finish;
  end

  // Test sequence.
  initial begin
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= prs_pkg::RegScaleX;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    point_x_i   <= '0;
    point_y_i   <= '0;
    burst_left = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_identity_extremes();
    test_angle_folding();
    test_saturation();
    test_rounding_ties();
    test_pivot_only();
    test_unused_index();
    test_random_settings(30, 60);

    // Let the pipeline drain, then watch a little longer for stray results.
    in_valid_i <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (2 * PipeLatency) @(posedge clk_i);

    $display("Sent %0d points across %0d register writes; %0d results checked.",
             points_sent, cfg_writes, results_checked);
    $display("%0d results were saturated; %0d field mismatches.", saturated_results,
             error_count);
    if (error_count == 0) begin
      $display("PASS point_rotate_scale_about_pivot_unit");
    end else begin
      $display("FAIL point_rotate_scale_about_pivot_unit");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/prs_pkg.sv
rtl/prs_rotate.sv
rtl/prs_scale.sv
rtl/point_rotate_scale_about_pivot_unit.sv
dv/tb_point_rotate_scale_about_pivot_unit.sv
